// ===== rtl/debug_packet_deframer_unit_assert.svh =====
// Assertion macros used by the deframer checker.
`ifndef DEBUG_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define DEBUG_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define DPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, switched off while reset is high.
`define DPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ===== rtl/dpd_pkg.sv =====
package dpd_pkg;

  localparam int CountW = 12;
  localparam logic [CountW-1:0] MaxBodyBytes = 12'd2048;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [2:0] EV_BODY  = 3'd0;
  localparam logic [2:0] EV_GOOD  = 3'd1;
  localparam logic [2:0] EV_BAD   = 3'd2;
  localparam logic [2:0] EV_ACK   = 3'd3;
  localparam logic [2:0] EV_NAK   = 3'd4;
  localparam logic [2:0] EV_BREAK = 3'd5;

  typedef enum logic [2:0] {
    CLS_START,
    CLS_END,
    CLS_ACK,
    CLS_NAK,
    CLS_BREAK,
    CLS_OTHER
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
    logic        hex_ok;
    logic [3:0]  nib;
  } token_t;

endpackage

// ===== rtl/dpd_front.sv =====
module dpd_front (
  input  logic            push,
  input  logic [7:0]      rx_byte,
  input  logic            q_full,
  output logic            wr_en,
  output dpd_pkg::token_t wr_token
);
  import dpd_pkg::*;

  localparam logic [7:0] ChStart = 8'h24;
  localparam logic [7:0] ChEnd   = 8'h23;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChBreak = 8'h03;

  logic is_digit;
  logic is_lower;
  logic is_upper;

  assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign is_lower = (rx_byte >= 8'h61) && (rx_byte <= 8'h66);
  assign is_upper = (rx_byte >= 8'h41) && (rx_byte <= 8'h46);

  always_comb begin
    wr_token.data   = rx_byte;
    wr_token.hex_ok = is_digit || is_lower || is_upper;
    // Letters a-f and A-F share their low nibble; adding nine gives the value.
    if (is_digit) begin
      wr_token.nib = rx_byte[3:0];
    end else if (is_lower || is_upper) begin
      wr_token.nib = rx_byte[3:0] + 4'd9;
    end else begin
      wr_token.nib = 4'd0;
    end
    case (rx_byte)
      ChStart: wr_token.cls = CLS_START;
      ChEnd:   wr_token.cls = CLS_END;
      ChPlus:  wr_token.cls = CLS_ACK;
      ChMinus: wr_token.cls = CLS_NAK;
      ChBreak: wr_token.cls = CLS_BREAK;
      default: wr_token.cls = CLS_OTHER;
    endcase
  end

  assign wr_en = push && !q_full;

endmodule

// ===== rtl/dpd_queue.sv =====
module dpd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  dpd_pkg::token_t wr_token,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output dpd_pkg::token_t rd_token
);
  import dpd_pkg::*;

  token_t               slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;
  logic                 do_rd;

  assign full     = (count == (QueuePtrW+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_token = slots[rd_ptr];
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_token;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dpd_back.sv =====
module dpd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  input  dpd_pkg::token_t tok,
  output logic            tok_take,
  input  logic            pop,
  output logic            empty,
  output logic [2:0]      event_kind,
  output logic [7:0]      event_data
);
  import dpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_DIG1,
    PH_DIG2
  } phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic              digit_bad, digit_bad_next;
  logic [CountW-1:0] body_count, body_count_next;
  logic              body_overflow, body_overflow_next;
  logic              out_valid, out_valid_next;
  logic [2:0]        out_kind, out_kind_next;
  logic [7:0]        out_data, out_data_next;
  logic [3:0]        nib_val;
  logic              frame_good;

  // A token moves on whenever the result register is free or is being emptied.
  assign tok_take = tok_valid && (!out_valid || pop);

  assign nib_val    = tok.hex_ok ? tok.nib : 4'd0;
  assign frame_good = !digit_bad && tok.hex_ok && !body_overflow &&
                      ({high_nibble, nib_val} == running_sum);

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    high_nibble_next   = high_nibble;
    digit_bad_next     = digit_bad;
    body_count_next    = body_count;
    body_overflow_next = body_overflow;
    out_valid_next     = out_valid && !pop;
    out_kind_next      = out_kind;
    out_data_next      = out_data;
    if (tok_take) begin
      case (phase)
        PH_HUNT: begin
          case (tok.cls)
            CLS_START: begin
              phase_next         = PH_BODY;
              running_sum_next   = 8'd0;
              high_nibble_next   = 4'd0;
              digit_bad_next     = 1'b0;
              body_count_next    = '0;
              body_overflow_next = 1'b0;
            end
            CLS_ACK: begin
              out_valid_next = 1'b1;
              out_kind_next  = EV_ACK;
              out_data_next  = 8'd0;
            end
            CLS_NAK: begin
              out_valid_next = 1'b1;
              out_kind_next  = EV_NAK;
              out_data_next  = 8'd0;
            end
            CLS_BREAK: begin
              out_valid_next = 1'b1;
              out_kind_next  = EV_BREAK;
              out_data_next  = 8'd0;
            end
            default: begin
            end
          endcase
        end
        PH_BODY: begin
          if (tok.cls == CLS_END) begin
            phase_next = PH_DIG1;
          end else if (body_count >= MaxBodyBytes) begin
            body_overflow_next = 1'b1;
          end else begin
            body_count_next  = body_count + 1'b1;
            running_sum_next = running_sum + tok.data;
            out_valid_next   = 1'b1;
            out_kind_next    = EV_BODY;
            out_data_next    = tok.data;
          end
        end
        PH_DIG1: begin
          high_nibble_next = nib_val;
          digit_bad_next   = digit_bad || !tok.hex_ok;
          phase_next       = PH_DIG2;
        end
        default: begin
          digit_bad_next = digit_bad || !tok.hex_ok;
          phase_next     = PH_HUNT;
          out_valid_next = 1'b1;
          out_kind_next  = frame_good ? EV_GOOD : EV_BAD;
          out_data_next  = running_sum;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      running_sum   <= 8'd0;
      high_nibble   <= 4'd0;
      digit_bad     <= 1'b0;
      body_count    <= '0;
      body_overflow <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      high_nibble   <= high_nibble_next;
      digit_bad     <= digit_bad_next;
      body_count    <= body_count_next;
      body_overflow <= body_overflow_next;
      out_valid     <= out_valid_next;
    end
    out_kind <= out_kind_next;
    out_data <= out_data_next;
  end

  assign empty      = !out_valid;
  assign event_kind = out_kind;
  assign event_data = out_data;

endmodule

// ===== rtl/debug_packet_deframer_unit.sv =====
// Path: an accepted byte is stored in the token queue; any result is then registered for popping.
// Throughput: one byte per cycle; the classifier, a four-entry token queue and the
// frame sequencer each handle one token a cycle, so only a held result slows intake.
// Reset: synchronous on rst; it empties the token queue and result register and
// returns the sequencer to hunting for a frame start.
module debug_packet_deframer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] event_kind,
  output logic [7:0] event_data
);
  import dpd_pkg::*;

  logic   wr_en;
  token_t wr_token;
  logic   rd_valid;
  logic   rd_en;
  token_t rd_token;

  dpd_front u_front (
    .push     (push),
    .rx_byte  (rx_byte),
    .q_full   (full),
    .wr_en    (wr_en),
    .wr_token (wr_token)
  );

  dpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_token (wr_token),
    .full     (full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_token (rd_token)
  );

  dpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (rd_valid),
    .tok        (rd_token),
    .tok_take   (rd_en),
    .pop        (pop),
    .empty      (empty),
    .event_kind (event_kind),
    .event_data (event_data)
  );

endmodule

// ===== rtl/dpd_checker.sv =====
`include "debug_packet_deframer_unit_assert.svh"

module dpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [2:0] event_kind,
  input logic [7:0] event_data
);
  import dpd_pkg::*;

  logic ctrl_event;

  assign ctrl_event = (event_kind == EV_ACK) || (event_kind == EV_NAK) ||
                      (event_kind == EV_BREAK);

  // The queue only fills while a result is being held back.
  `DPD_ASSERT_NOW(full_implies_result, full, !empty)
  `DPD_ASSERT_NOW(kind_in_range, !empty, event_kind <= EV_BREAK)
  `DPD_ASSERT_NOW(ctrl_data_zero, !empty && ctrl_event, event_data == 8'd0)
  `DPD_ASSERT_NEXT(result_held, !empty && !pop,
                   !empty && $stable(event_kind) && $stable(event_data))

endmodule

bind debug_packet_deframer_unit dpd_checker u_dpd_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .event_kind (event_kind),
  .event_data (event_data)
);
